### rtl/xor_sprite_blitter_with_scroll_top_macros.svh
// assertion macros used by the checker file of the sprite blitter
// depends on nothing; included by bare file name
`ifndef XOR_SPRITE_BLITTER_WITH_SCROLL_TOP_MACROS_SVH
`define XOR_SPRITE_BLITTER_WITH_SCROLL_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define XSB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sprite blitter assertion failed");

// next-cycle implication, disabled in reset
`define XSB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sprite blitter assertion failed");

`endif

### rtl/xsb_pkg.sv
// types and constants of the xor sprite blitter
// no dependencies
package xsb_pkg;

    // action codes of an input item
    typedef enum logic [2:0] {
        ACT_DRAW  = 3'd0,
        ACT_DOWN  = 3'd1,
        ACT_LEFT  = 3'd2,
        ACT_RIGHT = 3'd3,
        ACT_READ  = 3'd4
    } act_t;

    // display modes
    localparam logic [1:0] MODE_LOW   = 2'd0;
    localparam logic [1:0] MODE_HALF  = 2'd1;
    localparam logic [1:0] MODE_SUPER = 2'd2;

    // operations of the shared line unit
    typedef enum logic [2:0] {
        LOP_DRAW  = 3'd0,
        LOP_LEFT  = 3'd1,
        LOP_RIGHT = 3'd2,
        LOP_COPY  = 3'd3,
        LOP_ZERO  = 3'd4
    } lop_t;

    // control bundle from the sequencer to the line unit
    typedef struct packed {
        lop_t        op;
        logic [1:0]  mode;
        logic [7:0]  x;
        logic [15:0] bits;
        logic        wide;
        logic        test_en;
        logic [5:0]  line;
    } line_ctl_t;

    localparam int WORD_W   = 64;
    localparam int WORDS    = 128;
    localparam int SHIFT_PX = 4;

endpackage

### rtl/xsb_if.sv
// request and response channel interfaces of the sprite blitter
// no dependencies
interface xsb_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [3:0]  row_index;
    logic [15:0] row_bits;
    logic        row_wide;
    logic        last_row;
    logic [3:0]  scroll_lines;
    logic [5:0]  read_row;
    logic        read_half;

    modport source (output valid, action, x, y, row_index, row_bits, row_wide, last_row,
                    scroll_lines, read_row, read_half, input ready);
    modport sink (input valid, action, x, y, row_index, row_bits, row_wide, last_row,
                  scroll_lines, read_row, read_half, output ready);
endinterface

interface xsb_rsp_if;
    logic        valid;
    logic        ready;
    logic        collision;
    logic [63:0] read_data;

    modport source (output valid, collision, read_data, input ready);
    modport sink (input valid, collision, read_data, output ready);
endinterface

### rtl/xsb_ram.sv
// generic single write, single registered read ram
// no dependencies
module xsb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### rtl/xsb_line_unit.sv
// shared line unit: transforms one 128-pixel framebuffer line
// depends on xsb_pkg
module xsb_line_unit #(
    parameter int FB_WIDTH  = 128,
    parameter int FB_HEIGHT = 64
) (
    input  xsb_pkg::line_ctl_t ctl,
    input  logic [127:0]       old_line,
    output logic [127:0]       new_line,
    output logic               hit
);
    logic [127:0] mask;
    logic [127:0] test;
    logic [127:0] wmask;
    logic [127:0] lmask;
    logic [127:0] eff;
    logic         line_ok;

    // columns that exist at this width
    always_comb
    begin
        for (int i = 0; i < 128; i++)
        begin
            wmask[i] = (i < FB_WIDTH);
            lmask[i] = (i + xsb_pkg::SHIFT_PX < FB_WIDTH);
        end
    end

    assign line_ok = ({1'b0, ctl.line} < 7'(FB_HEIGHT));

    // pixel mask of the sprite row, one lane per sprite bit
    always_comb
    begin
        logic [6:0] col;
        logic       pix;
        mask = '0;
        test = '0;
        for (int b = 0; b < 16; b++)
        begin
            col = ctl.x[6:0] + 7'(b);
            if (ctl.mode == xsb_pkg::MODE_SUPER)
            begin
                if (ctl.wide)
                begin
                    pix = ctl.bits[15 - b];
                end
                else if (b < 8)
                begin
                    pix = ctl.bits[(7 - b) & 7];
                end
                else
                begin
                    pix = 1'b0;
                end
                if (pix)
                begin
                    mask[col] = 1'b1;
                    test[col] = 1'b1;
                end
            end
            else if (b < 8)
            begin
                pix = ctl.bits[(7 - b) & 7];
                if (pix)
                begin
                    mask[{col[5:0], 1'b0}] = 1'b1;
                    mask[{col[5:0], 1'b1}] = 1'b1;
                    test[{col[5:0], 1'b0}] = 1'b1;
                end
            end
        end
    end

    assign eff = mask & wmask & {128{line_ok}};

    // operation select
    always_comb
    begin
        hit = 1'b0;
        case (ctl.op)
            xsb_pkg::LOP_DRAW:
            begin
                new_line = old_line ^ eff;
                hit      = ctl.test_en && (|(old_line & eff & test));
            end
            xsb_pkg::LOP_LEFT:
                new_line = (((old_line >> xsb_pkg::SHIFT_PX) & lmask) & wmask)
                           | (old_line & ~wmask);
            xsb_pkg::LOP_RIGHT:
                new_line = ((old_line << xsb_pkg::SHIFT_PX) & wmask) | (old_line & ~wmask);
            xsb_pkg::LOP_COPY:
                new_line = old_line;
            default:
                new_line = '0;
        endcase
    end
endmodule

### rtl/xor_sprite_blitter_with_scroll_top.sv
// draw row: read and write of each line (1 line, 2 in low-res), then the result is handed over;
// scrolls: all FB_HEIGHT lines, then the result; read word: one line read, no write back;
// other actions go straight to the result; the single frame ram port pair, used
// read-read-write-write per line, sets the rate; one item at a time, ready again in the cycle
// after the result loads; a new item is taken while the last result still waits
// rst_n async low: idle, mode 0, collision clear, all line valid bits clear (blank screen)
module xor_sprite_blitter_with_scroll_top #(
    parameter int FB_WIDTH  = 128,
    parameter int FB_HEIGHT = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    xsb_req_if.sink     req,
    xsb_rsp_if.source   rsp
);
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_RD0  = 6'b000010,
        ST_RD1  = 6'b000100,
        ST_WR0  = 6'b001000,
        ST_WR1  = 6'b010000,
        ST_FIN  = 6'b100000
    } state_t;

    state_t       state_reg, state_next;
    logic [1:0]   mode_reg;
    logic [2:0]   act_reg;
    logic [7:0]   x_reg;
    logic [15:0]  bits_reg;
    logic         wide_reg, last_reg, half_reg;
    logic [3:0]   lines_reg;
    logic [5:0]   base_reg, cnt_reg;
    logic         ok_reg;
    logic [63:0]  lo_reg, hi_new_reg, data_reg;
    logic         seen_reg;
    logic [63:0]  vld_reg;
    logic         rsp_valid_reg, rsp_coll_reg;
    logic [63:0]  rsp_data_reg;

    logic [5:0]   dst, src;
    logic         copy_ok;
    logic [7:0]   y_sum;
    logic         accept, load_rsp;
    logic [6:0]   raddr, waddr;
    logic         we;
    logic [63:0]  wdata, rdata, rdata_g;
    logic [127:0] new_line;
    logic         hit;
    xsb_pkg::line_ctl_t ctl;

    // config port
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {30'd0, mode_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= xsb_pkg::MODE_LOW;
        end
        else if (psel && penable && pwrite && !paddr[2])
        begin
            mode_reg <= pwdata[1:0];
        end
    end

    // line addressing
    assign dst     = base_reg + cnt_reg;
    assign copy_ok = ({2'b00, cnt_reg} >= {4'd0, lines_reg});
    assign src     = (act_reg == xsb_pkg::ACT_DOWN && copy_ok) ?
                     cnt_reg - {2'b00, lines_reg} : dst;
    assign y_sum   = req.y + {4'd0, req.row_index};
    assign accept  = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign load_rsp  = (state_reg == ST_FIN) && (!rsp_valid_reg || rsp.ready);

    // shared line unit
    always_comb
    begin
        case (act_reg)
            xsb_pkg::ACT_DRAW:  ctl.op = xsb_pkg::LOP_DRAW;
            xsb_pkg::ACT_LEFT:  ctl.op = xsb_pkg::LOP_LEFT;
            xsb_pkg::ACT_RIGHT: ctl.op = xsb_pkg::LOP_RIGHT;
            xsb_pkg::ACT_DOWN:  ctl.op = copy_ok ? xsb_pkg::LOP_COPY : xsb_pkg::LOP_ZERO;
            default:            ctl.op = xsb_pkg::LOP_COPY;
        endcase
        ctl.mode    = mode_reg;
        ctl.x       = x_reg;
        ctl.bits    = bits_reg;
        ctl.wide    = wide_reg;
        ctl.test_en = (cnt_reg == 6'd0);
        ctl.line    = dst;
    end

    assign rdata_g = ok_reg ? rdata : 64'd0;

    xsb_line_unit #(
        .FB_WIDTH  (FB_WIDTH),
        .FB_HEIGHT (FB_HEIGHT)
    ) u_line (
        .ctl      (ctl),
        .old_line ({rdata_g, lo_reg}),
        .new_line (new_line),
        .hit      (hit)
    );

    // frame store
    assign raddr = {src, (state_reg == ST_RD1)};
    assign we    = ((state_reg == ST_WR0) || (state_reg == ST_WR1))
                   && (act_reg != xsb_pkg::ACT_READ);
    assign waddr = {dst, (state_reg == ST_WR1)};
    assign wdata = (state_reg == ST_WR1) ? hi_new_reg : new_line[63:0];

    xsb_ram #(
        .WIDTH (xsb_pkg::WORD_W),
        .DEPTH (xsb_pkg::WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    state_next = (req.action <= xsb_pkg::ACT_READ) ? ST_RD0 : ST_FIN;
                end
            ST_RD0: state_next = ST_RD1;
            ST_RD1: state_next = ST_WR0;
            ST_WR0: state_next = (act_reg == xsb_pkg::ACT_READ) ? ST_FIN : ST_WR1;
            ST_WR1: state_next = (cnt_reg == 6'd0) ? ST_FIN : ST_RD0;
            ST_FIN: state_next = load_rsp ? ST_IDLE : ST_FIN;
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seen_reg      <= 1'b0;
            vld_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            act_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                act_reg <= req.action;
                if (req.action == xsb_pkg::ACT_DRAW && mode_reg != xsb_pkg::MODE_SUPER
                    && mode_reg != xsb_pkg::MODE_HALF)
                begin
                    cnt_reg <= 6'd1;
                end
                else if (req.action == xsb_pkg::ACT_DOWN || req.action == xsb_pkg::ACT_LEFT
                         || req.action == xsb_pkg::ACT_RIGHT)
                begin
                    cnt_reg <= 6'(FB_HEIGHT - 1);
                end
                else
                begin
                    cnt_reg <= 6'd0;
                end
            end
            else if (state_reg == ST_WR1 && cnt_reg != 6'd0)
            begin
                cnt_reg <= cnt_reg - 6'd1;
            end
            if (we)
            begin
                vld_reg[dst] <= 1'b1;
            end
            if (state_reg == ST_WR0 && act_reg == xsb_pkg::ACT_DRAW && hit)
            begin
                seen_reg <= 1'b1;
            end
            else if (load_rsp && act_reg == xsb_pkg::ACT_DRAW && last_reg)
            begin
                seen_reg <= 1'b0;
            end
            if (load_rsp)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg     <= req.x;
            bits_reg  <= req.row_bits;
            wide_reg  <= req.row_wide;
            last_reg  <= req.last_row;
            lines_reg <= req.scroll_lines;
            half_reg  <= req.read_half;
            data_reg  <= 64'd0;
            if (req.action == xsb_pkg::ACT_READ)
            begin
                base_reg <= req.read_row;
            end
            else if (req.action == xsb_pkg::ACT_DRAW)
            begin
                base_reg <= (mode_reg == xsb_pkg::MODE_SUPER || mode_reg == xsb_pkg::MODE_HALF)
                            ? y_sum[5:0] : {y_sum[4:0], 1'b0};
            end
            else
            begin
                base_reg <= 6'd0;
            end
        end
        if (state_reg == ST_RD0)
        begin
            ok_reg <= vld_reg[src];
        end
        if (state_reg == ST_RD1)
        begin
            lo_reg <= rdata_g;
        end
        if (state_reg == ST_WR0)
        begin
            hi_new_reg <= new_line[127:64];
            if (act_reg == xsb_pkg::ACT_READ)
            begin
                data_reg <= half_reg ? rdata_g : lo_reg;
            end
        end
        if (load_rsp)
        begin
            rsp_coll_reg <= seen_reg;
            rsp_data_reg <= data_reg;
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.collision = rsp_coll_reg;
    assign rsp.read_data = rsp_data_reg;
endmodule

### rtl/xsb_checker.sv
// port-level checker of the sprite blitter, bound to the top level
// depends on the macros header and xor_sprite_blitter_with_scroll_top
`include "xor_sprite_blitter_with_scroll_top_macros.svh"

module xsb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic        rsp_collision,
    input logic [63:0] rsp_read_data
);
    // a stalled result holds its payload
    `XSB_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_read_data) && $stable(rsp_collision))
    // one item at a time: busy right after a transfer in
    `XSB_ASSERT_NEXT(a_busy_after, clk, rst_n, req_valid && req_ready, !req_ready)
    // ready only drops because an item came in
    `XSB_ASSERT_NOW(a_ready_drop, clk, rst_n, $fell(req_ready), $past(req_valid))
endmodule

bind xor_sprite_blitter_with_scroll_top xsb_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_collision (rsp.collision),
    .rsp_read_data (rsp.read_data)
);

### bench/tb_xor_sprite_blitter_with_scroll_top.sv
// self-checking bench for the xor sprite blitter with scroll
// depends on xsb_pkg, xsb_if and the top module xor_sprite_blitter_with_scroll_top
`timescale 1ns / 100ps

module tb_xor_sprite_blitter_with_scroll_top;

    localparam int FB_W = 128;
    localparam int FB_H = 64;
    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;
    localparam logic [2:0] ADDR_MODE = 3'd0;
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam logic [2:0] ACT_SPARE_LO = 3'd5;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [3:0]  row_index;
        logic [15:0] row_bits;
        logic        row_wide;
        logic        last_row;
        logic [3:0]  scroll_lines;
        logic [5:0]  read_row;
        logic        read_half;
    } blit_item_t;

    typedef struct packed {
        logic        collision;
        logic [63:0] read_data;
    } blit_result_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    xsb_req_if req ();
    xsb_rsp_if rsp ();

    xor_sprite_blitter_with_scroll_top dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .req(req), .rsp(rsp)
    );

    // shadow of the block state
    logic [63:0] shadow_fb [xsb_pkg::WORDS];
    logic [1:0]  shadow_mode;
    logic        shadow_hit;

    blit_item_t   pending_items [$];
    blit_result_t expected_results [$];

    int errors;
    int accepted;
    int results_seen;
    int idle_cycles;
    int draw_count;
    int scroll_count;
    int read_count;
    int hold_cnt;
    bit hold_rsp;
    bit hold_done;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // pixel access on the shadow framebuffer
    function automatic bit pix_get(int line, int col);
        return shadow_fb[((line & 63) << 1) | ((col >> 6) & 1)][col & 63];
    endfunction

    function automatic void pix_put(int line, int col, bit v);
        shadow_fb[((line & 63) << 1) | ((col >> 6) & 1)][col & 63] = v;
    endfunction

    function automatic bit pix_toggle(int line, int col);
        bit nv;
        if (line >= FB_H || col >= FB_W)
            return 1'b0;
        nv = !pix_get(line, col);
        pix_put(line, col, nv);
        return !nv;
    endfunction

    function automatic bit blit_row(int x, int y, int bits, bit wide);
        bit hit;
        int n;
        int top;
        int c;
        int l;
        hit = 1'b0;
        n = 8;
        top = 'h80;
        if (shadow_mode == xsb_pkg::MODE_SUPER && wide)
        begin
            n = 16;
            top = 'h8000;
        end
        for (int b = 0; b < n; b++)
        begin
            if (bits & (top >> b))
            begin
                if (shadow_mode == xsb_pkg::MODE_SUPER)
                    hit |= pix_toggle(y & 'h3F, (x + b) & 'h7F);
                else if (shadow_mode == xsb_pkg::MODE_HALF)
                begin
                    c = ((x + b) & 'h3F) << 1;
                    l = y & 'h3F;
                    hit |= pix_toggle(l, c);
                    void'(pix_toggle(l, c + 1));
                end
                else
                begin
                    c = ((x + b) & 'h3F) << 1;
                    l = (y & 'h1F) << 1;
                    hit |= pix_toggle(l, c);
                    void'(pix_toggle(l, c + 1));
                    void'(pix_toggle(l + 1, c));
                    void'(pix_toggle(l + 1, c + 1));
                end
            end
        end
        return hit;
    endfunction

    // expected result of one transfer, updating the shadow state
    function automatic blit_result_t blit_predict(blit_item_t it);
        blit_result_t r;
        r.read_data = '0;
        case (it.action)
            xsb_pkg::ACT_DRAW:
            begin
                if (blit_row(it.x, it.y + it.row_index, it.row_bits, it.row_wide))
                    shadow_hit = 1'b1;
            end
            xsb_pkg::ACT_DOWN:
            begin
                for (int l = FB_H - 1; l >= 0; l--)
                begin
                    if (l >= it.scroll_lines)
                    begin
                        shadow_fb[2*l]   = shadow_fb[2*(l - it.scroll_lines)];
                        shadow_fb[2*l+1] = shadow_fb[2*(l - it.scroll_lines) + 1];
                    end
                    else
                    begin
                        shadow_fb[2*l]   = '0;
                        shadow_fb[2*l+1] = '0;
                    end
                end
            end
            xsb_pkg::ACT_LEFT:
            begin
                for (int l = 0; l < FB_H; l++)
                    for (int c = 0; c < FB_W; c++)
                        pix_put(l, c, (c + xsb_pkg::SHIFT_PX < FB_W) ?
                                pix_get(l, c + xsb_pkg::SHIFT_PX) : 1'b0);
            end
            xsb_pkg::ACT_RIGHT:
            begin
                for (int l = 0; l < FB_H; l++)
                    for (int c = FB_W - 1; c >= 0; c--)
                        pix_put(l, c, (c >= xsb_pkg::SHIFT_PX) ?
                                pix_get(l, c - xsb_pkg::SHIFT_PX) : 1'b0);
            end
            xsb_pkg::ACT_READ: r.read_data = shadow_fb[{it.read_row, it.read_half}];
            default: ;
        endcase
        r.collision = shadow_hit;
        if (it.action == xsb_pkg::ACT_DRAW && it.last_row)
            shadow_hit = 1'b0;
        return r;
    endfunction

    function automatic blit_item_t rand_item();
        blit_item_t it;
        it = blit_item_t'({$urandom, $urandom});
        if ($urandom_range(0, 99) < 65)
            it.action = xsb_pkg::ACT_DRAW;
        else if ($urandom_range(0, 99) < 70)
            it.action = xsb_pkg::ACT_READ;
        else
            it.action = 3'($urandom_range(1, 7));
        it.last_row = ($urandom_range(0, 3) == 0);
        return it;
    endfunction

    function automatic blit_item_t make_item(logic [2:0] act, int x, int y, int ri, int bits,
                                             bit wide, bit last);
        blit_item_t it;
        it = '0;
        it.action = act;
        it.x = 8'(x);
        it.y = 8'(y);
        it.row_index = 4'(ri);
        it.row_bits = 16'(bits);
        it.row_wide = wide;
        it.last_row = last;
        return it;
    endfunction

    function automatic blit_item_t make_read(int row, bit half);
        blit_item_t it;
        it = make_item(xsb_pkg::ACT_READ, 0, 0, 0, 0, 1'b0, 1'b0);
        it.read_row = 6'(row);
        it.read_half = half;
        return it;
    endfunction

    // driver: bursts with random gaps
    int gap_left;
    int burst_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.action <= '0;
            req.x <= '0;
            req.y <= '0;
            req.row_index <= '0;
            req.row_bits <= '0;
            req.row_wide <= 1'b0;
            req.last_row <= 1'b0;
            req.scroll_lines <= '0;
            req.read_row <= '0;
            req.read_half <= 1'b0;
            gap_left <= 0;
            burst_left <= 0;
        end
        else if (!req.valid || req.ready)
        begin
            if (req.valid && req.ready)
                void'(pending_items.pop_front());
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                req.valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                blit_item_t it;
                it = pending_items[0];
                req.valid <= 1'b1;
                {req.action, req.x, req.y, req.row_index, req.row_bits, req.row_wide,
                 req.last_row, req.scroll_lines, req.read_row, req.read_half} <= it;
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(0, 20);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                req.valid <= 1'b0;
        end
    end

    // receiver stall pattern, with one long counted hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            hold_cnt <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_rsp && !hold_done)
        begin
            rsp.ready <= 1'b0;
            if (hold_cnt == HOLD_CYCLES - 1)
                hold_done <= 1'b1;
            hold_cnt <= hold_cnt + 1;
        end
        else
            rsp.ready <= ($urandom_range(0, 7) < 5);
    end

    // monitor: predict on accepted input, check on accepted result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req.valid && req.ready)
            begin
                blit_item_t it;
                it = {req.action, req.x, req.y, req.row_index, req.row_bits, req.row_wide,
                      req.last_row, req.scroll_lines, req.read_row, req.read_half};
                expected_results.push_back(blit_predict(it));
                accepted++;
                if (it.action == xsb_pkg::ACT_DRAW) draw_count++;
                else if (it.action == xsb_pkg::ACT_READ) read_count++;
                else if (it.action inside {xsb_pkg::ACT_DOWN, xsb_pkg::ACT_LEFT,
                                           xsb_pkg::ACT_RIGHT}) scroll_count++;
            end
            if (rsp.valid && rsp.ready)
            begin
                blit_result_t ex;
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with nothing expected, collision %0b data %h",
                             $time, rsp.collision, rsp.read_data);
                end
                else
                begin
                    ex = expected_results.pop_front();
                    if (ex.collision !== rsp.collision)
                    begin
                        errors++;
                        $display("%0t: collision expected %0b actual %0b",
                                 $time, ex.collision, rsp.collision);
                    end
                    if (ex.read_data !== rsp.read_data)
                    begin
                        errors++;
                        $display("%0t: read_data expected %h actual %h",
                                 $time, ex.read_data, rsp.read_data);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready)
            || (pending_items.size() == 0 && expected_results.size() == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic reg_write(logic [2:0] addr, logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || req.valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (4 * FB_H + 20) @(posedge clk);
    endtask

    task automatic load_display_mode(logic [1:0] m);
        wait_drained();
        reg_write(ADDR_MODE, {30'd0, m});
        shadow_mode = m;
    endtask

    task automatic run_random(int n);
        for (int i = 0; i < n; i++)
            pending_items.push_back(rand_item());
    endtask

    // well-formed sprites of random content, each followed by one random read
    task automatic run_sprites(int n);
        int x;
        int y;
        int rows;
        for (int s = 0; s < n; s++)
        begin
            x = $urandom_range(0, 255);
            y = $urandom_range(0, 255);
            rows = $urandom_range(1, 16);
            for (int r = 0; r < rows; r++)
                pending_items.push_back(make_item(xsb_pkg::ACT_DRAW, x, y, r, $urandom,
                                                  $urandom_range(0, 1), r == rows - 1));
            pending_items.push_back(make_read($urandom_range(0, 63), $urandom_range(0, 1)));
        end
    endtask

    logic [1:0] mode_plan [5] = '{xsb_pkg::MODE_SUPER, xsb_pkg::MODE_LOW, xsb_pkg::MODE_HALF,
                                  MODE_SPARE, xsb_pkg::MODE_SUPER};

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        hold_rsp = 1'b0;
        errors = 0;
        accepted = 0;
        results_seen = 0;
        draw_count = 0;
        scroll_count = 0;
        read_count = 0;
        shadow_mode = xsb_pkg::MODE_LOW;
        shadow_hit = 1'b0;
        for (int i = 0; i < xsb_pkg::WORDS; i++)
            shadow_fb[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: extremes, collisions, scrolls, undefined actions (low-res at reset)
        pending_items.push_back(make_item(xsb_pkg::ACT_DRAW, 0, 0, 0, 'hFF, 1'b0, 1'b0));
        pending_items.push_back(make_item(xsb_pkg::ACT_DRAW, 0, 0, 0, 'h81, 1'b1, 1'b1));
        pending_items.push_back(make_item(xsb_pkg::ACT_DRAW, 255, 255, 15, 'hFFFF, 1'b1, 1'b1));
        pending_items.push_back(make_read(0, 0));
        pending_items.push_back(make_read(63, 1));
        pending_items.push_back(make_item(xsb_pkg::ACT_RIGHT, 0, 0, 0, 0, 1'b0, 1'b0));
        pending_items.push_back(make_read(0, 0));
        pending_items.push_back(make_item(xsb_pkg::ACT_LEFT, 0, 0, 0, 0, 1'b0, 1'b0));
        begin
            blit_item_t it;
            it = make_item(xsb_pkg::ACT_DOWN, 0, 0, 0, 0, 1'b0, 1'b0);
            it.scroll_lines = 4'd15;
            pending_items.push_back(it);
            it.scroll_lines = 4'd0;
            pending_items.push_back(it);
        end
        pending_items.push_back(make_item(ACT_SPARE_LO, 0, 0, 0, 0, 1'b0, 1'b1));
        pending_items.push_back(make_item(ACT_SPARE_HI, 0, 0, 0, 0, 1'b0, 1'b1));
        pending_items.push_back(make_read(30, 0));
        run_random(10);

        // long receiver hold-off while the sender keeps offering
        load_display_mode(xsb_pkg::MODE_SUPER);
        pending_items.push_back(make_item(xsb_pkg::ACT_DRAW, 120, 60, 3, 'hFFFF, 1'b1, 1'b0));
        pending_items.push_back(make_item(xsb_pkg::ACT_DRAW, 120, 60, 3, 'hFFFF, 1'b1, 1'b1));
        pending_items.push_back(make_item(xsb_pkg::ACT_RIGHT, 0, 0, 0, 0, 1'b0, 1'b0));
        pending_items.push_back(make_read(63, 1));
        hold_rsp = 1'b1;
        run_random(40);
        wait (hold_done);
        hold_rsp = 1'b0;

        // random phases over every mode, with the undefined mode as well
        foreach (mode_plan[m])
        begin
            load_display_mode(mode_plan[m]);
            run_sprites(12);
            run_random(90);
        end
        wait_drained();

        $display("covered %0d transfers: %0d draws, %0d scrolls, %0d reads over modes 0 to 3",
                 accepted, draw_count, scroll_count, read_count);
        if (errors == 0 && expected_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
